// File: rtl/core/ifhg_pkg.sv
// ----------------------------------------------------------------------------
// ifhg_pkg: shared types and constants of the IPv4 fragment header generator
// Holds the request and header beat layouts, the controller/datapath
// command and status groups, the state encoding and the header constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ifhg_pkg;

  // Header geometry: 1500-byte MTU less a 20-byte header gives the piece size.
  localparam int unsigned MtuBytes   = 1500;
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned PieceBytes = MtuBytes - HdrBytes;

  localparam logic [15:0] VerIhlTos   = 16'h4500;
  localparam logic [7:0]  TtlValue    = 8'hFF;
  localparam logic [31:0] BcastAddr   = 32'hFFFF_FFFF;
  localparam logic [10:0] PieceLen    = 11'(PieceBytes);
  localparam logic [10:0] HdrLen      = 11'(HdrBytes);

  // One send request.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic        link_dest_given;
  } req_t;

  // One fragment header description.
  typedef struct packed {
    logic [10:0] total_length;
    logic [15:0] ident;
    logic [13:0] frag_word;
    logic [7:0]  proto_out;
    logic [31:0] src_out;
    logic [31:0] dst_out;
    logic [15:0] header_checksum;
    logic [15:0] payload_offset;
    logic [10:0] fragment_length;
    logic        broadcast_mac;
    logic        last;
  } hdr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a request
    logic emit;   // produce one fragment into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_empty;  // incoming request has no payload
    logic frag_last;  // the pending fragment is the final one
    logic out_room;   // output register can take a beat this cycle
  } ctrl_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage : ifhg_pkg

`default_nettype wire

// File: rtl/core/ifhg_ctrl.sv
// ----------------------------------------------------------------------------
// ifhg_ctrl: request sequencer
// Accepts a request when idle, then steps the datapath once per fragment
// whenever the output register has room, returning to idle after the last.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhg_ctrl
  import ifhg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && !sts.req_empty) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.out_room;
        if (sts.out_room && sts.frag_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule : ifhg_ctrl

`default_nettype wire

// File: rtl/core/ifhg_dp.sv
// ----------------------------------------------------------------------------
// ifhg_dp: fragment datapath
// Holds the captured request, the identification counter and the local
// address, cuts the payload into pieces and builds each header with its
// checksum into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhg_dp
  import ifhg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire req_t        in_data,
  input  wire ctrl_cmd_t   cmd,
  output ctrl_sts_t        sts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output hdr_t             out_data
);

  logic [31:0] local_address;
  logic [15:0] ident_counter;

  logic [15:0] remain;
  logic [15:0] offset;
  logic [7:0]  proto;
  logic [31:0] src;
  logic [31:0] dst;
  logic [15:0] id;
  logic        bcast;
  logic [19:0] base_sum;

  logic [31:0] src_sel;
  logic [19:0] base_sum_next;
  logic        last;
  logic [10:0] flen;
  logic [13:0] fw;
  logic [10:0] tlen;
  logic [20:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Configuration register and identification counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
      ident_counter <= '0;
    end else begin
      if (cfg_wr_en) begin
        local_address <= cfg_wr_data;
      end
      if (cmd.load) begin
        ident_counter <= ident_counter + 16'd1;
      end
    end
  end

  // Fixed part of the header sum, taken from the request being accepted.
  always_comb begin
    src_sel = (in_data.source_address == '0) ? local_address : in_data.source_address;
    base_sum_next = 20'(VerIhlTos) + 20'({TtlValue, in_data.protocol})
                  + 20'(ident_counter)
                  + 20'(src_sel[31:16]) + 20'(src_sel[15:0])
                  + 20'(in_data.dest_address[31:16]) + 20'(in_data.dest_address[15:0]);
  end

  // Request registers: loaded on accept, stepped per fragment.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remain   <= in_data.payload_length;
      offset   <= '0;
      proto    <= in_data.protocol;
      src      <= src_sel;
      dst      <= in_data.dest_address;
      id       <= ident_counter;
      bcast    <= !in_data.link_dest_given && (in_data.dest_address == BcastAddr);
      base_sum <= base_sum_next;
    end else if (cmd.emit) begin
      remain <= remain - 16'(flen);
      offset <= offset + 16'(flen);
    end
  end

  // Current fragment and its checksum: add the varying words and fold twice.
  always_comb begin
    last  = (remain <= 16'(PieceLen));
    flen  = last ? remain[10:0] : PieceLen;
    fw    = {!last, offset[15:3]};
    tlen  = HdrLen + flen;
    sum   = 21'(base_sum) + 21'(tlen) + 21'(fw);
    fold1 = 17'(sum[15:0]) + 17'(sum[20:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.total_length    <= tlen;
      out_data.ident           <= id;
      out_data.frag_word       <= fw;
      out_data.proto_out       <= proto;
      out_data.src_out         <= src;
      out_data.dst_out         <= dst;
      out_data.header_checksum <= ~fold2;
      out_data.payload_offset  <= offset;
      out_data.fragment_length <= flen;
      out_data.broadcast_mac   <= bcast;
      out_data.last            <= last;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.req_empty = (in_data.payload_length == '0);
    sts.frag_last = last;
    sts.out_room  = !out_valid || !out_stall;
  end

endmodule : ifhg_dp

`default_nettype wire

// File: rtl/core/ipv4_fragment_header_generator_top.sv
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator_top: IPv4 fragment header generator
// Turns one send request into one header description per 1480-byte
// fragment, with identification, fragment field and header checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (in_valid, in_stall, in_data) takes one beat per
//   send request. The result channel (out_valid, out_stall, out_data)
//   gives one beat per fragment, in order, with last set on the final one.
//   A request is accepted only while the sequencer is idle. It produces
//   ceil(payload_length / 1480) beats, from 1 up to 45, one per cycle into
//   the output register while the receiver does not stall; the first beat
//   is valid once the sequencer has entered its emit state and the output
//   register has been loaded. A zero-length request produces no beat, still
//   advances the identification, and the next request can be taken in the following cycle.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits; nothing is dropped.
//   cfg_wr_en/cfg_wr_data set the local address used for a zero source;
//   write it only while idle. Synchronous reset clears the identification
//   counter, the local address and all handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_fragment_header_generator_top
  import ifhg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output hdr_t             out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer.
  ifhg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  ifhg_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule : ipv4_fragment_header_generator_top

`default_nettype wire

// File: rtl/core/ifhg_checker.sv
// ----------------------------------------------------------------------------
// ifhg_checker: port-level checks for the fragment header generator
// Watches the top-level ports and flags inconsistent result beats and
// sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module ifhg_checker
  import ifhg_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire req_t in_data,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire hdr_t out_data
);

  // No result beat right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // The last flag and the more-fragments bit agree.
  a_last_mf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == !out_data.frag_word[13]))
    else $error("last flag disagrees with more-fragments bit");

  // Total length is header plus fragment payload.
  a_tlen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.total_length == out_data.fragment_length + HdrLen))
    else $error("total length mismatch");

  // A non-empty request keeps the request side stalled in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.payload_length != '0) |=> in_stall)
    else $error("request accepted while fragments pending");

endmodule : ifhg_checker

bind ipv4_fragment_header_generator_top ifhg_checker u_ifhg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/tb_ipv4_fragment_header_generator_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_fragment_header_generator_top: self-checking bench for the IPv4
// fragment header generator
// Send requests are queued by a stimulus process and fed to the block by a
// clocked driver. A clocked monitor predicts the fragment headers of every
// accepted request and checks each header beat against the oldest one.
// The run covers directed corner cases, requests around piece
// boundaries, and random requests under three idling patterns and
// several local addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ipv4_fragment_header_generator_top;
  import ifhg_pkg::*;

  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxPrinted  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hdr_t        out_data;

  // Requests waiting to be driven and headers waiting to come out.
  req_t        pending_requests[$];
  hdr_t        expected_headers[$];

  // Mirror of the block's state.
  logic [15:0] next_ident;
  logic [31:0] local_addr_mirror;

  int unsigned send_idle_pct = 13;
  int unsigned recv_stall_pct = 53;
  int unsigned error_count = 0;
  logic        request_taken = 1'b0;

  ipv4_fragment_header_generator_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  always #6 clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Internet checksum over the 20-byte header with TTL 255 and a zero
  // checksum field.
  function automatic logic [15:0] ipv4_checksum(input hdr_t h);
    int unsigned sum;
    sum = VerIhlTos + h.total_length + h.ident + h.frag_word
        + {TtlValue, h.proto_out}
        + h.src_out[31:16] + h.src_out[15:0]
        + h.dst_out[31:16] + h.dst_out[15:0];
    while ((sum >> 16) != 0) begin
      sum = (sum & 32'hFFFF) + (sum >> 16);
    end
    return 16'(~sum);
  endfunction

  // Cuts one request into 1480-byte pieces and queues their headers.
  // The identification advances even when no piece is produced.
  task automatic predict_fragments(input req_t r);
    int unsigned len;
    int unsigned off;
    int unsigned flen;
    logic        is_last;
    hdr_t        h;
    len = r.payload_length;
    off = 0;
    while (off < len) begin
      flen = (len - off > PieceBytes) ? PieceBytes : len - off;
      is_last = (off + flen >= len);
      h.total_length    = HdrLen + 11'(flen);
      h.ident           = next_ident;
      h.frag_word       = {!is_last, 13'(off >> 3)};
      h.proto_out       = r.protocol;
      h.src_out         = (r.source_address == '0) ? local_addr_mirror
                                                    : r.source_address;
      h.dst_out         = r.dest_address;
      h.payload_offset  = 16'(off);
      h.fragment_length = 11'(flen);
      h.broadcast_mac   = !r.link_dest_given && (r.dest_address == BcastAddr);
      h.last            = is_last;
      h.header_checksum = ipv4_checksum(h);
      expected_headers.push_back(h);
      off += flen;
    end
    next_ident = next_ident + 16'd1;
  endtask

  function automatic req_t make_request(input int unsigned len,
                                        input logic [7:0] proto,
                                        input logic [31:0] src,
                                        input logic [31:0] dst,
                                        input logic link);
    req_t r;
    r.payload_length  = 16'(len);
    r.protocol        = proto;
    r.source_address  = src;
    r.dest_address    = dst;
    r.link_dest_given = link;
    return r;
  endfunction

  // Mostly short datagrams, some at or one byte off piece boundaries, a few of any
  // size up to the field's limit, and the odd empty one.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.payload_length = '0;
    end else if (pick < 15) begin
      r.payload_length = 16'($urandom);
    end else if (pick < 25) begin
      r.payload_length = 16'(PieceBytes * $urandom_range(4, 1) + $urandom_range(2) - 1);
    end else begin
      r.payload_length = 16'($urandom_range(3000, 1));
    end
    r.protocol        = 8'($urandom_range(255));
    r.source_address  = ($urandom_range(99) < 25) ? 32'h0 : 32'($urandom);
    r.dest_address    = ($urandom_range(99) < 20) ? BcastAddr : 32'($urandom);
    r.link_dest_given = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic enqueue_request(input req_t r);
    pending_requests.push_back(r);
  endtask

  task automatic enqueue_random(input int unsigned count);
    repeat (count) enqueue_request(random_request());
  endtask

  // Waits until every request is taken and every header has come out,
  // then lets the block settle.
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_requests.size() != 0 || in_valid ||
               expected_headers.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_local_address(input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Driver: a new request beat is offered only once the previous one has
  // been taken; the receiver side stalls at random.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || request_taken) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
    request_taken = 1'b0;
  end

  // Monitor: tracks configuration writes, predicts on every accepted
  // request and checks every accepted header beat.
  always @(posedge clk) begin
    hdr_t want;
    if (rst) begin
      next_ident        = '0;
      local_addr_mirror = '0;
    end else begin
      if (cfg_wr_en) begin
        local_addr_mirror = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        predict_fragments(in_data);
        request_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          report_mismatch($sformatf("header beat with none expected: %h", out_data));
        end else begin
          want = expected_headers.pop_front();
          check_field("total_length", out_data.total_length, want.total_length);
          check_field("ident", out_data.ident, want.ident);
          check_field("frag_word", out_data.frag_word, want.frag_word);
          check_field("proto_out", out_data.proto_out, want.proto_out);
          check_field("src_out", out_data.src_out, want.src_out);
          check_field("dst_out", out_data.dst_out, want.dst_out);
          check_field("header_checksum", out_data.header_checksum,
                      want.header_checksum);
          check_field("payload_offset", out_data.payload_offset,
                      want.payload_offset);
          check_field("fragment_length", out_data.fragment_length,
                      want.fragment_length);
          check_field("broadcast_mac", out_data.broadcast_mac, want.broadcast_mac);
          check_field("last", out_data.last, want.last);
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A zero source before any write picks up the reset local address.
    send_idle_pct  = 13;
    recv_stall_pct = 53;
    enqueue_request(make_request(1, 8'd1, 32'h0, 32'h0A00_0002, 1'b0));
    wait_idle();
    write_local_address(32'($urandom));

    // Directed corners: smallest and largest pieces, piece boundaries,
    // broadcast with and without a link destination, an empty request and
    // the largest datagrams.
    enqueue_request(make_request(1, 8'd0, 32'h0, 32'h0, 1'b0));
    enqueue_request(make_request(PieceBytes, 8'd255, BcastAddr, BcastAddr, 1'b0));
    enqueue_request(make_request(PieceBytes + 1, 8'd17, 32'h0A00_0001, BcastAddr, 1'b1));
    enqueue_request(make_request(0, 8'd6, 32'h0, BcastAddr, 1'b0));
    enqueue_request(make_request(2 * PieceBytes, 8'd6, 32'h0, 32'h0A00_00FF, 1'b0));
    enqueue_request(make_request(2 * PieceBytes + 1, 8'd1, 32'hC0A8_0002,
                                 32'hFFFF_FFFE, 1'b0));
    enqueue_request(make_request(7, 8'd132, 32'h0, BcastAddr, 1'b0));
    enqueue_request(make_request(65535, 8'd255, 32'h0, BcastAddr, 1'b0));
    enqueue_request(make_request(65515, 8'd17, BcastAddr, 32'h0, 1'b1));

    // A few requests of one and two pieces back to back.
    enqueue_request(make_request(100, 8'd6, 32'h0, 32'h0A01_0203, 1'b0));
    enqueue_request(make_request(PieceBytes + 100, 8'd17, 32'h0A01_0204,
                                 BcastAddr, 1'b0));
    enqueue_request(make_request(100, 8'd6, 32'h0, 32'h0A01_0205, 1'b1));

    enqueue_random(150);
    wait_idle();

    // Second phase: lazy sender, busy receiver, all-ones local address.
    send_idle_pct  = 53;
    recv_stall_pct = 13;
    write_local_address(32'hFFFF_FFFF);
    enqueue_random(150);
    wait_idle();

    // Third phase: no idling, zero local address.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_local_address(32'h0);
    enqueue_random(150);
    wait_idle();

    if (error_count == 0) begin
      $display("tb_ipv4_fragment_header_generator_top passed");
    end else begin
      $display("tb_ipv4_fragment_header_generator_top failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #24000000;
    $display("tb_ipv4_fragment_header_generator_top failed");
    $finish;
  end

endmodule : tb_ipv4_fragment_header_generator_top

`default_nettype wire
